// ===== hw/rtl/csvfs_pkg.sv =====
// ----------------------------------------------------------------------------
// csvfs_pkg
// Shared types and constants of the CSV line field splitter: character codes,
// parse modes, field limits and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

	// Character codes that steer the parser.
	localparam logic [7:0] QUOTE_CHAR = 8'h22;
	localparam logic [7:0] COMMA_CHAR = 8'h2C;

	// Field limits.
	localparam int FIELD_CAPACITY = 16;
	localparam logic [4:0] LIMIT_MAX = 5'(FIELD_CAPACITY);
	localparam logic [4:0] LIMIT_MIN = 5'd1;
	localparam logic [4:0] LIMIT_RESET = 5'd16;

	// Parse modes.
	localparam logic [1:0] MODE_START = 2'd0;
	localparam logic [1:0] MODE_PLAIN = 2'd1;
	localparam logic [1:0] MODE_QUOTED = 2'd2;
	localparam logic [1:0] MODE_QSEEN = 2'd3;

	// One result word.
	typedef struct packed {
		logic [7:0] content_byte;
		logic [3:0] field_number;
		logic       field_close;
		logic       line_done;
		logic [4:0] fields_found;
	} result_t;

	// Parser output toward the output buffer.
	typedef struct packed {
		logic    valid;
		result_t res;
	} parse_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/csvfs_parser.sv =====
// ----------------------------------------------------------------------------
// csvfs_parser
// Per-byte CSV decision logic with its line state (mode, field count, drop
// flag). Produces zero or one result word for every accepted input word.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_parser (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [7:0]            text_byte,
	input  wire logic                  end_marker,
	input  wire logic [4:0]            field_limit,
	output csvfs_pkg::parse_out_t      pout
);
	import csvfs_pkg::*;

	logic [1:0] mode_q;
	logic [4:0] count_q;
	logic       drop_q;

	logic [1:0] mode_d;
	logic [4:0] count_d;
	logic       drop_d;
	logic [4:0] lim;
	logic [4:0] count_m1;
	logic       is_quote;
	logic       is_comma;

	assign is_quote = (text_byte == QUOTE_CHAR);
	assign is_comma = (text_byte == COMMA_CHAR);
	assign count_m1 = count_q - 5'd1;

	// Clamp the configured limit into its legal range.
	always_comb begin
		lim = field_limit;
		if (lim < LIMIT_MIN) begin
			lim = LIMIT_MIN;
		end
		if (lim > LIMIT_MAX) begin
			lim = LIMIT_MAX;
		end
	end

	// Decide the result and the next line state for the current word.
	always_comb begin
		logic emit;
		logic comma;
		emit = 1'b0;
		comma = 1'b0;
		mode_d = mode_q;
		count_d = count_q;
		drop_d = drop_q;
		pout = '0;

		if (end_marker) begin
			pout.valid = 1'b1;
			pout.res.field_number = count_m1[3:0];
			pout.res.field_close = ~drop_q;
			pout.res.line_done = 1'b1;
			pout.res.fields_found = count_q;
			mode_d = MODE_START;
			count_d = 5'd1;
			drop_d = 1'b0;
		end else if (!drop_q) begin
			case (mode_q)
				MODE_QUOTED: begin
					if (is_quote) begin
						mode_d = MODE_QSEEN;
					end else begin
						emit = 1'b1;
					end
				end
				MODE_QSEEN: begin
					if (is_quote) begin
						mode_d = MODE_QUOTED;
						emit = 1'b1;
					end else if (is_comma) begin
						comma = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
						emit = 1'b1;
					end
				end
				MODE_START: begin
					if (is_comma) begin
						comma = 1'b1;
					end else if (is_quote) begin
						mode_d = MODE_QUOTED;
					end else begin
						mode_d = MODE_PLAIN;
						emit = 1'b1;
					end
				end
				default: begin
					if (is_comma) begin
						comma = 1'b1;
					end else begin
						mode_d = MODE_PLAIN;
						emit = 1'b1;
					end
				end
			endcase

			// An ordinary content byte of the current field.
			if (emit) begin
				pout.valid = 1'b1;
				pout.res.content_byte = text_byte;
				pout.res.field_number = count_m1[3:0];
				pout.res.fields_found = count_q;
			end

			// A field-ending comma; at the limit it starts dropping the line.
			if (comma) begin
				mode_d = MODE_START;
				if (count_q < lim) begin
					count_d = count_q + 5'd1;
				end else begin
					drop_d = 1'b1;
				end
				pout.valid = 1'b1;
				pout.res.field_number = count_m1[3:0];
				pout.res.field_close = 1'b1;
				pout.res.fields_found = count_d;
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
			count_q <= 5'd1;
			drop_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			count_q <= count_d;
			drop_q <= drop_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csvfs_out_buf.sv =====
// ----------------------------------------------------------------------------
// csvfs_out_buf
// Two-entry result buffer. It decouples the parser from the receiver so that
// a new word is taken while a finished result still waits, and its ready is
// a registered full flag.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_out_buf (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  csvfs_pkg::result_t       push_res,
	output logic                     full,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output csvfs_pkg::result_t       out_res
);
	import csvfs_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full = (count_q == 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_res = slot_q[rd_ptr_q];
	assign pop = out_valid & out_ready;

	// Result storage; no reset needed on the payload.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_res;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/csv_line_field_splitter.sv =====
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// Splits one CSV line, fed a byte per word and closed by an end-of-line word,
// into unquoted field content bytes, field-close marks and a line-done mark.
//
// Input channel (in_valid/in_ready): text_byte and end_marker, one word per
// accepted handshake. Output channel (out_valid/out_ready): one result word
// with content_byte, field_number, field_close, line_done and fields_found.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_data sets
// field_limit. The user writes it only while the block is idle; not enforced.
//
// Throughput is one input word per cycle unless the result buffer is full.
// Each word yields zero or one result, pushed into that buffer when the
// word is accepted. The per-byte decision and the state update happen in
// the acceptance cycle. A two-entry result buffer sits between parser and
// receiver; in_ready is low only while that buffer is full, so a stalled
// receiver holds results in order and pushes back after two waiting words.
// Reset empties the buffer, returns the line state to the start of a line
// with one field, and sets field_limit to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_line_field_splitter (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_marker,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      content_byte,
	output logic [3:0]      field_number,
	output logic            field_close,
	output logic            line_done,
	output logic [4:0]      fields_found,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [4:0] cfg_data
);
	import csvfs_pkg::*;

	logic [4:0] field_limit_q;
	logic       accept;
	logic       buf_full;
	parse_out_t pout;
	result_t    out_res;

	assign in_ready = ~buf_full;
	assign accept = in_valid & in_ready;
	assign cfg_ready = 1'b1;

	// Field limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			field_limit_q <= cfg_data;
		end
	end

	// Per-byte parser with the line state.
	csvfs_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_marker  (end_marker),
		.field_limit (field_limit_q),
		.pout        (pout)
	);

	// Result buffer toward the receiver.
	csvfs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept & pout.valid),
		.push_res  (pout.res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign content_byte = out_res.content_byte;
	assign field_number = out_res.field_number;
	assign field_close = out_res.field_close;
	assign line_done = out_res.line_done;
	assign fields_found = out_res.fields_found;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Block-level test of csv_line_field_splitter. The testbench feeds lines of
// CSV text, one byte word at a time and closed by an end-of-line word. It
// predicts each result word with its own copy of the parser state and checks
// the output against the prediction in order. Directed lines cover quoting
// and field limits. Random phases sweep the limit register and mix
// well-formed lines with noise. Both sides stall at random, and one long
// receiver hold-off fills the block.
// ----------------------------------------------------------------------------

module testbench;
	import csvfs_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT = 20;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte = 8'h00;
	logic       end_marker = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] content_byte;
	logic [3:0] field_number;
	logic       field_close;
	logic       line_done;
	logic [4:0] fields_found;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [4:0] cfg_data = 5'd0;

	// Shadow of the parser state and the limit register.
	logic [1:0] parse_state = MODE_START;
	logic [4:0] line_fields = 5'd1;
	logic       drop_rest = 1'b0;
	logic [4:0] field_limit = LIMIT_RESET;

	result_t    awaited_results[$];
	int         mismatches = 0;
	int         words_sent = 0;
	bit         quiet = 1'b0;
	bit         hold_pending = 1'b0;

	csv_line_field_splitter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_marker   (end_marker),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.content_byte (content_byte),
		.field_number (field_number),
		.field_close  (field_close),
		.line_done    (line_done),
		.fields_found (fields_found),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The limit as the parser applies it: zero acts as one, and values above
	// the field capacity are clipped.
	function automatic logic [4:0] active_limit();
		if (field_limit < LIMIT_MIN)
			return LIMIT_MIN;
		if (field_limit > LIMIT_MAX)
			return LIMIT_MAX;
		return field_limit;
	endfunction

	// Advances the shadow parser by one word and returns 1 when the word
	// yields a result.
	function automatic bit split_byte(input logic [7:0] b, input logic eol,
			output result_t r);
		r = '0;
		if (eol) begin
			r.field_number = 4'(line_fields - 5'd1);
			r.field_close = !drop_rest;
			r.line_done = 1'b1;
			r.fields_found = line_fields;
			parse_state = MODE_START;
			line_fields = 5'd1;
			drop_rest = 1'b0;
			return 1'b1;
		end
		if (drop_rest)
			return 1'b0;
		if (parse_state == MODE_QUOTED) begin
			if (b == QUOTE_CHAR) begin
				parse_state = MODE_QSEEN;
				return 1'b0;
			end
		end else if (parse_state == MODE_QSEEN && b == QUOTE_CHAR) begin
			// A doubled quote inside quotes stands for one quote.
			parse_state = MODE_QUOTED;
		end else if (b == COMMA_CHAR) begin
			r.field_number = 4'(line_fields - 5'd1);
			r.field_close = 1'b1;
			if (line_fields < active_limit())
				line_fields = line_fields + 5'd1;
			else
				drop_rest = 1'b1;
			r.fields_found = line_fields;
			parse_state = MODE_START;
			return 1'b1;
		end else if (parse_state == MODE_START && b == QUOTE_CHAR) begin
			parse_state = MODE_QUOTED;
			return 1'b0;
		end else begin
			parse_state = MODE_PLAIN;
		end
		r.content_byte = b;
		r.field_number = 4'(line_fields - 5'd1);
		r.fields_found = line_fields;
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input result_t want,
			input result_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected byte=%02h field=%0d close=%b done=%b found=%0d, got byte=%02h field=%0d close=%b done=%b found=%0d",
				$realtime, what, want.content_byte, want.field_number,
				want.field_close, want.line_done, want.fields_found,
				seen.content_byte, seen.field_number, seen.field_close,
				seen.line_done, seen.fields_found);
	endtask

	// Sends one word, idling first at random, and records its prediction.
	task automatic send_word(input logic [7:0] b, input logic eol);
		result_t r;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_marker <= eol;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (split_byte(b, eol, r))
			awaited_results.push_back(r);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_word(s[i], 1'b0);
	endtask

	// Stops the input and waits until every expected result has come out.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_field_limit(input logic [4:0] v);
		wait_idle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		field_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// A byte for unquoted text: a quote is kept only past the field start.
	function automatic logic [7:0] plain_byte(input bit first);
		logic [7:0] ch;
		ch = 8'($urandom_range(255));
		if (ch == COMMA_CHAR || (ch == QUOTE_CHAR && first))
			ch = ch ^ 8'h80;
		else if (!first && $urandom_range(7) == 0)
			ch = QUOTE_CHAR;
		return ch;
	endfunction

	// One random line: mostly well-formed fields, sometimes raw noise.
	// With retune set, the limit may be rewritten between fields.
	task automatic send_random_line(input bit noisy, input bit retune);
		int n_fields;
		int len;
		int kind;
		logic [7:0] ch;
		if (noisy) begin
			len = $urandom_range(1, 12);
			repeat (len) begin
				case ($urandom_range(3))
					0: ch = QUOTE_CHAR;
					1: ch = COMMA_CHAR;
					default: ch = 8'($urandom_range(255));
				endcase
				send_word(ch, 1'b0);
			end
		end else begin
			n_fields = $urandom_range(1, 20);
			for (int f = 0; f < n_fields; f++) begin
				if (f != 0)
					send_word(COMMA_CHAR, 1'b0);
				if (retune && $urandom_range(15) == 0)
					set_field_limit(5'($urandom_range(31)));
				kind = $urandom_range(3);
				if (kind == 1) begin
					len = $urandom_range(1, 4);
					for (int i = 0; i < len; i++)
						send_word(plain_byte(i == 0), 1'b0);
				end else if (kind >= 2) begin
					send_word(QUOTE_CHAR, 1'b0);
					len = $urandom_range(0, 4);
					repeat (len) begin
						case ($urandom_range(3))
							0: send_word(COMMA_CHAR, 1'b0);
							1: begin
								send_word(QUOTE_CHAR, 1'b0);
								send_word(QUOTE_CHAR, 1'b0);
							end
							default: begin
								ch = 8'($urandom_range(255));
								if (ch == QUOTE_CHAR)
									ch = 8'h00;
								send_word(ch, 1'b0);
							end
						endcase
					end
					// The last field may end the line inside its quotes.
					if (f != n_fields - 1 || $urandom_range(3) != 0) begin
						send_word(QUOTE_CHAR, 1'b0);
						if ($urandom_range(3) == 0)
							send_word(plain_byte(1'b1), 1'b0);
					end
				end
			end
		end
		send_word(8'($urandom_range(255)), 1'b1);
	endtask

	// Quoted sections, doubled and literal quotes, empty fields, byte extremes
	// and a line that ends inside quotes.
	task automatic test_quoting();
		send_text("\"a\"\"b\"x,q\"z,");
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		send_word(8'hFF, 1'b1);
		send_text(",\",\",\"c");
		send_word(8'h00, 1'b1);
	endtask

	// A limit lowered below the field count in the middle of a line.
	task automatic test_limit_lowered();
		send_text("a,,");
		set_field_limit(5'd1);
		send_text("d,e");
		send_word(8'h41, 1'b1);
		set_field_limit(LIMIT_RESET);
	endtask

	// Random phases over a sweep of limit settings, the extremes first.
	task automatic test_random_lines();
		logic [4:0] limits[8];
		int phase_end;
		limits = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd17, 5'd2, 5'd0, 5'd0};
		limits[6] = 5'($urandom_range(31));
		limits[7] = 5'($urandom_range(1, 16));
		for (int p = 0; p < 8; p++) begin
			set_field_limit(limits[p]);
			quiet = (p == 3);
			phase_end = words_sent + 150;
			while (words_sent < phase_end)
				send_random_line($urandom_range(4) == 0, p[0]);
		end
		quiet = 1'b0;
	endtask

	// The receiver holds off long enough for the block to stall its input.
	task automatic test_backpressure();
		wait_idle();
		quiet = 1'b1;
		hold_pending = 1'b1;
		repeat (3) send_random_line(1'b0, 1'b0);
		quiet = 1'b0;
	endtask

	// Receiver: random stalls, or a counted hold-off when one is requested.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	// Each accepted result word is checked against the oldest prediction.
	always @(posedge clk) begin
		result_t seen;
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {content_byte, field_number, field_close, line_done, fields_found};
			if (awaited_results.size() == 0) begin
				note_mismatch("unexpected result", '0, seen);
			end else begin
				want = awaited_results.pop_front();
				if (seen.content_byte !== want.content_byte
						|| seen.field_number !== want.field_number
						|| seen.field_close !== want.field_close
						|| seen.line_done !== want.line_done
						|| seen.fields_found !== want.fields_found)
					note_mismatch("result mismatch", want, seen);
			end
		end
	end

	// Watchdog: ends the run when no word moves for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("csv_line_field_splitter test failed");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_quoting();
		test_limit_lowered();
		test_backpressure();
		test_random_lines();

		wait_idle();
		if (awaited_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("csv_line_field_splitter test passed");
		else
			$display("csv_line_field_splitter test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/csvfs_pkg.sv
hw/rtl/csvfs_parser.sv
hw/rtl/csvfs_out_buf.sv
hw/rtl/csv_line_field_splitter.sv
sim/testbench.sv
